// ===== sv/sept_pkg.sv =====
// Shared constants, codes and types for the sector erase/program tracker.
package sept_pkg;

   localparam int KIND_W       = 3;
   localparam int ADDR_W       = 22;
   localparam int LEN_W        = 23;
   localparam int SECTOR_WORDS = 65536;
   localparam int NUM_SECTORS  = 64;

   localparam int SECT_SHIFT = $clog2(SECTOR_WORDS);
   localparam int FIRST_W    = ADDR_W - SECT_SHIFT;
   localparam int COUNT_W    = LEN_W + 1 - SECT_SHIFT;
   localparam int SUM_W      = (FIRST_W > COUNT_W ? FIRST_W : COUNT_W) + 1;
   localparam int NSEC_W     = $clog2(NUM_SECTORS + 1);
   localparam int WALK_W     = SUM_W > NSEC_W ? SUM_W : NSEC_W;
   localparam int IDX_W      = NUM_SECTORS > 1 ? $clog2(NUM_SECTORS) : 1;

   localparam logic [KIND_W-1:0] KIND_CLEAR           = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MARK_ERASED     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MARK_PROGRAMMED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CHECK_PROGRAM   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CHECK_ERASE     = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             wr_erased;
      logic             wr_programmed;
      logic             rd_en;
      logic [IDX_W-1:0] addr;
   } map_cmd_type;

   typedef struct packed {
      logic erased;
      logic programmed;
   } map_rd_type;

endpackage

// ===== sv/sept_if.sv =====
// Request and response channel interfaces.
interface sept_req_if
   import sept_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ADDR_W-1:0] start_address;
   logic [LEN_W-1:0]  length;

   modport source (output valid, kind, start_address, length, input ready);
   modport sink   (input valid, kind, start_address, length, output ready);
endinterface

interface sept_rsp_if;
   logic valid;
   logic ready;
   logic allowed;
   logic out_of_range;

   modport source (output valid, allowed, out_of_range, input ready);
   modport sink   (input valid, allowed, out_of_range, output ready);
endinterface

// ===== sv/sept_maps.sv =====
// Erased and programmed sector maps with per-entry valid bits and registered reads.
module sept_maps
   import sept_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  map_cmd_type cmd,
   output map_rd_type  rd
);

   logic                   erased_mem     [NUM_SECTORS];
   logic                   programmed_mem [NUM_SECTORS];
   logic [NUM_SECTORS-1:0] erased_vld_ff;
   logic [NUM_SECTORS-1:0] erased_vld_in;
   logic [NUM_SECTORS-1:0] programmed_vld_ff;
   logic [NUM_SECTORS-1:0] programmed_vld_in;
   map_rd_type             rd_ff;

   always_comb begin
      erased_vld_in     = erased_vld_ff;
      programmed_vld_in = programmed_vld_ff;
      if (cmd.clear) begin
         erased_vld_in     = '0;
         programmed_vld_in = '0;
      end else begin
         if (cmd.wr_erased) begin
            erased_vld_in[cmd.addr] = 1'b1;
         end
         if (cmd.wr_programmed) begin
            programmed_vld_in[cmd.addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         erased_vld_ff     <= '0;
         programmed_vld_ff <= '0;
      end else begin
         erased_vld_ff     <= erased_vld_in;
         programmed_vld_ff <= programmed_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_erased) begin
         erased_mem[cmd.addr] <= 1'b1;
      end
      if (cmd.wr_programmed) begin
         programmed_mem[cmd.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff.erased     <= erased_mem[cmd.addr] & erased_vld_ff[cmd.addr];
         rd_ff.programmed <= programmed_mem[cmd.addr] & programmed_vld_ff[cmd.addr];
      end
   end

   assign rd = rd_ff;

endmodule

// ===== sv/sept_ctrl.sv =====
// Request sequencer: walks covered sectors, folds check results, holds the response.
module sept_ctrl
   import sept_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sept_req_if.sink    req_chan,
   sept_rsp_if.source  rsp_chan,
   output map_cmd_type map_cmd,
   input  map_rd_type  map_rd
);

   state_type         state_ff;
   state_type         state_in;
   logic [KIND_W-1:0] kind_ff;
   logic [KIND_W-1:0] kind_in;
   logic [WALK_W-1:0] idx_ff;
   logic [WALK_W-1:0] idx_in;
   logic [WALK_W-1:0] stop_ff;
   logic [WALK_W-1:0] stop_in;
   logic              allowed_ff;
   logic              allowed_in;
   logic              oor_ff;
   logic              oor_in;
   logic              pend_ff;
   logic              pend_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_allowed_ff;
   logic              rsp_allowed_in;
   logic              rsp_oor_ff;
   logic              rsp_oor_in;

   logic               req_acc;
   logic               load_rsp;
   logic               walk_kind;
   logic               is_check;
   logic [FIRST_W-1:0] first;
   logic [LEN_W:0]     len_sum;
   logic [LEN_W:0]     count_wide;
   logic [COUNT_W-1:0] count;
   logic [WALK_W-1:0]  first_ext;
   logic [WALK_W-1:0]  last_excl;
   logic [WALK_W-1:0]  stop_calc;
   logic               oor_calc;

   // Range decode of the incoming request
   assign first      = req_chan.start_address[ADDR_W-1:SECT_SHIFT];
   assign len_sum    = {1'b0, req_chan.length} + (LEN_W+1)'(SECTOR_WORDS - 1);
   assign count_wide = len_sum >> SECT_SHIFT;
   assign count      = count_wide[COUNT_W-1:0];
   assign first_ext  = WALK_W'(first);
   assign last_excl  = first_ext + WALK_W'(count);
   assign oor_calc   = (count != '0) && (last_excl > WALK_W'(NUM_SECTORS));
   assign stop_calc  = oor_calc ? WALK_W'(NUM_SECTORS) : last_excl;
   assign walk_kind  = req_chan.kind inside {[KIND_MARK_ERASED:KIND_CHECK_ERASE]};
   assign is_check   = kind_ff inside {KIND_CHECK_PROGRAM, KIND_CHECK_ERASE};

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (walk_kind && (first_ext < stop_calc)) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_WALK: begin
            if (idx_ff + WALK_W'(1) == stop_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_chan.ready        = (state_ff == ST_IDLE);
      map_cmd.clear         = req_acc && (req_chan.kind == KIND_CLEAR);
      map_cmd.wr_erased     = (state_ff == ST_WALK) && (kind_ff == KIND_MARK_ERASED);
      map_cmd.wr_programmed = (state_ff == ST_WALK) && (kind_ff == KIND_MARK_PROGRAMMED);
      map_cmd.rd_en         = (state_ff == ST_WALK) && is_check;
      map_cmd.addr          = idx_ff[IDX_W-1:0];
      rsp_chan.valid        = rsp_valid_ff;
      rsp_chan.allowed      = rsp_allowed_ff;
      rsp_chan.out_of_range = rsp_oor_ff;
   end

   // Datapath next values
   always_comb begin
      kind_in        = kind_ff;
      idx_in         = idx_ff;
      stop_in        = stop_ff;
      allowed_in     = allowed_ff;
      oor_in         = oor_ff;
      pend_in        = map_cmd.rd_en;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_oor_in     = rsp_oor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      if (req_acc) begin
         kind_in    = req_chan.kind;
         idx_in     = first_ext;
         stop_in    = stop_calc;
         allowed_in = 1'b1;
         oor_in     = oor_calc && walk_kind;
      end else begin
         if (state_ff == ST_WALK) begin
            idx_in = idx_ff + WALK_W'(1);
         end
         if (pend_ff) begin
            if (kind_ff == KIND_CHECK_PROGRAM) begin
               allowed_in = allowed_ff & map_rd.erased;
            end else begin
               allowed_in = allowed_ff & ~map_rd.programmed;
            end
         end
      end
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_allowed_in = allowed_ff;
         rsp_oor_in     = oor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      idx_ff         <= idx_in;
      stop_ff        <= stop_in;
      allowed_ff     <= allowed_in;
      oor_ff         <= oor_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

endmodule

// ===== sv/sector_erase_program_tracker.sv =====
// Top level of the sector erase/program tracker.
// A request passes from IDLE through WALK, which visits each covered sector inside the
// device, and DRAIN to FINISH; clear, unused kinds and empty ranges go straight to FINISH.
// No new request is taken until the current one has reached FINISH; the map memory
// port visits one sector per cycle. The next request is taken while a response waits.
// Reset clears both sector maps at once through their valid bits; no clearing pass.
module sector_erase_program_tracker
   import sept_pkg::*;
(
   input logic        clock,
   input logic        reset,
   sept_req_if.sink   req_chan,
   sept_rsp_if.source rsp_chan
);

   map_cmd_type map_cmd;
   map_rd_type  map_rd;

   sept_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .map_cmd  (map_cmd),
      .map_rd   (map_rd)
   );

   sept_maps u_maps (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .rd    (map_rd)
   );

   a_busy_after_transfer : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while a previous one is in flight");

   a_clear_alone : assert property (@(posedge clock) disable iff (reset)
      map_cmd.clear |-> !(map_cmd.wr_erased || map_cmd.wr_programmed || map_cmd.rd_en))
      else $error("map clear overlaps a map access");

   a_read_write_exclusive : assert property (@(posedge clock) disable iff (reset)
      map_cmd.rd_en |-> !(map_cmd.wr_erased || map_cmd.wr_programmed))
      else $error("map read and write in the same cycle");

endmodule
